// ----- hdl/xpf_pkg.sv -----
// Shared types, codes and sizes of the XOR parity FEC codec.
package xpf_pkg;

	localparam int MAX_SYMBOL_BYTES = 2048;
	localparam int MAX_SYMBOLS      = 255;
	localparam int ADDR_W           = $clog2(MAX_SYMBOL_BYTES);
	localparam int LEN_W            = $clog2(MAX_SYMBOL_BYTES + 1);

	// request types
	localparam logic [2:0] REQ_SOURCE = 3'd0;
	localparam logic [2:0] REQ_REPAIR = 3'd1;
	localparam logic [2:0] REQ_LOST   = 3'd2;
	localparam logic [2:0] REQ_END    = 3'd3;
	localparam logic [2:0] REQ_READ   = 3'd4;

	// status codes
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_INVALID    = 3'd1;
	localparam logic [2:0] STAT_TOO_LONG   = 3'd2;
	localparam logic [2:0] STAT_NONE_LOST  = 3'd3;
	localparam logic [2:0] STAT_MANY_LOST  = 3'd4;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// mode register values
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// operations queued between front and back
	localparam logic [2:0] OP_SRC_ENC = 3'd0;
	localparam logic [2:0] OP_SRC_DEC = 3'd1;
	localparam logic [2:0] OP_REPAIR  = 3'd2;
	localparam logic [2:0] OP_LOST    = 3'd3;
	localparam logic [2:0] OP_END_ENC = 3'd4;
	localparam logic [2:0] OP_END_DEC = 3'd5;
	localparam logic [2:0] OP_READ    = 3'd6;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic        symbol_end;
	} req_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [2:0]  status;
		logic [7:0]  out_byte;
		logic [11:0] out_length;
		logic [7:0]  lost_index;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]        code;
		logic [7:0]        data;
		logic [ADDR_W-1:0] idx;
		logic              idx_ok;
		logic              sym_end;
	} op_t;

endpackage

// ----- hdl/xpf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module xpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/xpf_front.sv -----
// Front end: accepts request items, drops those with no effect, maps the rest to operations.
module xpf_front (
	input  xpf_pkg::req_item_t req,
	input  logic               req_valid,
	input  logic               mode,
	input  logic               q_full,
	output logic               push,
	output xpf_pkg::op_t       op
);

	logic keep;

	always_comb begin
		keep    = 1'b1;
		op.code = xpf_pkg::OP_READ;
		unique case (req.req_type)
			xpf_pkg::REQ_SOURCE: begin
				op.code = (mode == xpf_pkg::MODE_DECODE) ? xpf_pkg::OP_SRC_DEC
				                                         : xpf_pkg::OP_SRC_ENC;
			end
			xpf_pkg::REQ_REPAIR: begin
				op.code = xpf_pkg::OP_REPAIR;
				keep    = (mode == xpf_pkg::MODE_DECODE);
			end
			xpf_pkg::REQ_LOST: begin
				op.code = xpf_pkg::OP_LOST;
				keep    = (mode == xpf_pkg::MODE_DECODE);
			end
			xpf_pkg::REQ_END: begin
				op.code = (mode == xpf_pkg::MODE_DECODE) ? xpf_pkg::OP_END_DEC
				                                         : xpf_pkg::OP_END_ENC;
			end
			xpf_pkg::REQ_READ: begin
				op.code = xpf_pkg::OP_READ;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		op.data    = req.data_byte;
		op.idx     = req.byte_index[xpf_pkg::ADDR_W-1:0];
		op.idx_ok  = (req.byte_index < 16'(xpf_pkg::MAX_SYMBOL_BYTES));
		op.sym_end = req.symbol_end;
	end

	assign push = req_valid && !q_full && keep;

endmodule

// ----- hdl/xpf_queue.sv -----
// Two-entry operation queue between front and back.
module xpf_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  xpf_pkg::op_t push_op,
	input  logic         pop,
	output xpf_pkg::op_t head,
	output logic         empty,
	output logic         full
);

	xpf_pkg::op_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ----- hdl/xpf_back.sv -----
// Back end: block state, parity RAM sequencing and the result register.
module xpf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  xpf_pkg::op_t       head,
	input  logic               q_empty,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output xpf_pkg::rsp_item_t rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_RMW  = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;

	localparam logic [1:0] LOST_SAT = 2'd2;

	logic [2:0]                state_q;
	xpf_pkg::op_t              op_q;
	logic [xpf_pkg::LEN_W-1:0] len_q;
	logic                      ovf_q;
	logic [7:0]                count_q;
	logic [1:0]                lost_cnt_q;
	logic [7:0]                lost_pos_q;
	logic                      closed_q;
	logic                      out_valid_q;
	xpf_pkg::rsp_item_t        out_q;

	logic                       ram_we;
	logic [xpf_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0]                 ram_wdata;
	logic                       ram_re;
	logic [7:0]                 ram_rdata;

	logic [xpf_pkg::LEN_W-1:0] idx_ext;
	logic                      in_len;
	logic                      out_free;
	logic                      out_load;
	xpf_pkg::rsp_item_t        out_next;
	logic                      head_opens;
	logic [2:0]                end_stat;
	logic [7:0]                count_inc;

	assign idx_ext    = {1'b0, op_q.idx};
	assign in_len     = op_q.idx_ok && (idx_ext < len_q);
	assign out_free   = !out_valid_q || !rsp_stall;
	assign head_opens = (head.code == xpf_pkg::OP_SRC_ENC) || (head.code == xpf_pkg::OP_SRC_DEC)
	                 || (head.code == xpf_pkg::OP_REPAIR) || (head.code == xpf_pkg::OP_LOST);
	assign count_inc  = (count_q < 8'(xpf_pkg::MAX_SYMBOLS)) ? count_q + 8'd1 : count_q;

	always_comb begin
		if (op_q.code == xpf_pkg::OP_END_DEC) begin
			if (count_q < 8'd2 || ovf_q || len_q == '0) begin
				end_stat = xpf_pkg::STAT_INVALID;
			end else if (lost_cnt_q == 2'd0) begin
				end_stat = xpf_pkg::STAT_NONE_LOST;
			end else if (lost_cnt_q == LOST_SAT) begin
				end_stat = xpf_pkg::STAT_MANY_LOST;
			end else begin
				end_stat = xpf_pkg::STAT_OK;
			end
		end else begin
			if (count_q == 8'd0) begin
				end_stat = xpf_pkg::STAT_INVALID;
			end else if (ovf_q) begin
				end_stat = xpf_pkg::STAT_TOO_LONG;
			end else if (len_q == '0) begin
				end_stat = xpf_pkg::STAT_INVALID;
			end else begin
				end_stat = xpf_pkg::STAT_OK;
			end
		end
	end

	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = op_q.idx;
		ram_wdata = op_q.data;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		out_next.result_kind = xpf_pkg::KIND_READ;
		out_next.status      = xpf_pkg::STAT_OK;
		out_next.out_byte    = 8'd0;
		out_next.out_length  = len_q;
		out_next.lost_index  = 8'd0;
		unique case (state_q)
			ST_IDLE: begin
				pop = !q_empty;
			end
			ST_EXEC: begin
				unique case (op_q.code)
					xpf_pkg::OP_SRC_ENC, xpf_pkg::OP_SRC_DEC, xpf_pkg::OP_READ: begin
						ram_re = in_len;
						if (op_q.code == xpf_pkg::OP_READ && !in_len) begin
							out_load = out_free;
						end
					end
					xpf_pkg::OP_REPAIR: begin
						ram_we = in_len;
					end
					xpf_pkg::OP_END_ENC, xpf_pkg::OP_END_DEC: begin
						out_load = out_free;
						out_next.result_kind = xpf_pkg::KIND_STATUS;
						out_next.status      = end_stat;
						out_next.out_length  = (end_stat == xpf_pkg::STAT_OK) ? len_q : '0;
						out_next.lost_index  = (end_stat == xpf_pkg::STAT_OK
						                        && op_q.code == xpf_pkg::OP_END_DEC)
						                       ? lost_pos_q : 8'd0;
					end
					default: begin
					end
				endcase
			end
			ST_FILL: begin
				// zero the gap one entry a cycle, then place the byte itself
				ram_we    = 1'b1;
				ram_waddr = len_q[xpf_pkg::ADDR_W-1:0];
				ram_wdata = (len_q == idx_ext) ? op_q.data : 8'd0;
			end
			ST_RMW: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata ^ op_q.data;
			end
			ST_READ: begin
				out_load          = out_free;
				out_next.out_byte = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			count_q     <= 8'd0;
			lost_cnt_q  <= 2'd0;
			lost_pos_q  <= 8'd0;
			closed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_EXEC;
						if (closed_q && head_opens) begin
							len_q      <= '0;
							ovf_q      <= 1'b0;
							count_q    <= 8'd0;
							lost_cnt_q <= 2'd0;
							lost_pos_q <= 8'd0;
							closed_q   <= 1'b0;
						end
					end
				end
				ST_EXEC: begin
					unique case (op_q.code)
						xpf_pkg::OP_SRC_ENC: begin
							if (!op_q.idx_ok) begin
								ovf_q   <= 1'b1;
								state_q <= ST_IDLE;
								if (op_q.sym_end) begin
									count_q <= count_inc;
								end
							end else begin
								state_q <= in_len ? ST_RMW : ST_FILL;
							end
						end
						xpf_pkg::OP_SRC_DEC: begin
							if (in_len) begin
								state_q <= ST_RMW;
							end else begin
								state_q <= ST_IDLE;
								if (op_q.sym_end) begin
									count_q <= count_inc;
								end
							end
						end
						xpf_pkg::OP_REPAIR: begin
							if (!op_q.idx_ok) begin
								ovf_q   <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= in_len ? ST_IDLE : ST_FILL;
							end
						end
						xpf_pkg::OP_LOST: begin
							lost_pos_q <= count_q;
							if (lost_cnt_q != LOST_SAT) begin
								lost_cnt_q <= lost_cnt_q + 2'd1;
							end
							count_q <= count_inc;
							state_q <= ST_IDLE;
						end
						xpf_pkg::OP_END_ENC, xpf_pkg::OP_END_DEC: begin
							if (out_free) begin
								closed_q <= 1'b1;
								state_q  <= ST_IDLE;
							end
						end
						xpf_pkg::OP_READ: begin
							if (in_len) begin
								state_q <= ST_READ;
							end else if (out_free) begin
								state_q <= ST_IDLE;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_FILL: begin
					if (len_q == idx_ext) begin
						len_q   <= idx_ext + 1'b1;
						state_q <= ST_IDLE;
						if (op_q.code == xpf_pkg::OP_SRC_ENC && op_q.sym_end) begin
							count_q <= count_inc;
						end
					end else begin
						len_q <= len_q + 1'b1;
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
					if (op_q.sym_end) begin
						count_q <= count_inc;
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	xpf_ram #(
		.WIDTH(8),
		.DEPTH(xpf_pkg::MAX_SYMBOL_BYTES)
	) u_parity_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(op_q.idx),
		.rdata(ram_rdata)
	);

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- hdl/xor_parity_fec_codec.sv -----
// Top level of the XOR parity FEC codec: mode register, front end, queue and back end.
//
// Request items are classified on acceptance: unknown requests, and repair bytes or lost
// markers in encode mode, are dropped at once; the rest enter a two-entry queue. The back
// end works one item at a time against a single-port-per-side parity RAM (2048 bytes).
// A lost marker, end of block, in-range repair byte or out-of-range read or source byte
// finishes in the execute step; a source byte that updates a stored byte adds a
// read-modify-write step, an in-range read a read step, and a byte that extends the length
// first zeroes the never-written positions below it, one per cycle, then writes the byte.
// A result waits in an output register, so the back end keeps taking items that produce none.
// The mode register may only be written with no item in flight.
module xor_parity_fec_codec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  xpf_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output xpf_pkg::rsp_item_t rsp
);

	logic         mode_q;
	logic         q_push;
	logic         q_pop;
	logic         q_empty;
	logic         q_full;
	xpf_pkg::op_t push_op;
	xpf_pkg::op_t head_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= xpf_pkg::MODE_ENCODE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign req_stall = q_full;

	xpf_front u_front (
		.req      (req),
		.req_valid(req_valid),
		.mode     (mode_q),
		.q_full   (q_full),
		.push     (q_push),
		.op       (push_op)
	);

	xpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(push_op),
		.pop    (q_pop),
		.head   (head_op),
		.empty  (q_empty),
		.full   (q_full)
	);

	xpf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_op),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.out_length <= 12'(xpf_pkg::MAX_SYMBOL_BYTES))
		else $error("result length beyond symbol size");

	a_bad_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_kind == xpf_pkg::KIND_STATUS
		 && rsp.status != xpf_pkg::STAT_OK)
		|-> (rsp.out_length == 12'd0 && rsp.lost_index == 8'd0 && rsp.out_byte == 8'd0))
		else $error("failed status carries length or position");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_kind == xpf_pkg::KIND_READ)
		|-> (rsp.status == xpf_pkg::STAT_OK && rsp.lost_index == 8'd0))
		else $error("read result carries status fields");

endmodule

// ----- sim/xor_parity_fec_codec_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the XOR parity FEC codec: encode and decode blocks, reads, stalls.
module xor_parity_fec_codec_test;

	// the longest item (a length extension over the whole store) times the items in flight
	localparam int DRAIN_CYCLES = 3 * (3 + xpf_pkg::MAX_SYMBOL_BYTES) + 50;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

	class parity_scoreboard;
		logic [7:0]          par_mem [xpf_pkg::MAX_SYMBOL_BYTES];
		int unsigned         par_len;
		bit                  too_long;
		int unsigned         sym_cnt;
		int unsigned         lost_cnt;
		logic [7:0]          lost_at;
		bit                  closed;
		logic                mode;
		xpf_pkg::rsp_item_t  expected_replies[$];
		int                  errors;

		function void open_block();
			if (closed) begin
				par_len  = 0;
				too_long = 0;
				sym_cnt  = 0;
				lost_cnt = 0;
				lost_at  = '0;
				closed   = 0;
			end
		endfunction

		function void count_symbol();
			if (sym_cnt < xpf_pkg::MAX_SYMBOLS)
				sym_cnt++;
		endfunction

		// positions skipped over by a longer symbol read back as zero
		function void grow_to(int unsigned idx);
			if (idx >= par_len) begin
				for (int unsigned i = par_len; i <= idx; i++)
					par_mem[i] = '0;
				par_len = idx + 1;
			end
		endfunction

		function void note_request(xpf_pkg::req_item_t it);
			xpf_pkg::rsp_item_t r;
			logic [2:0]         st;
			int unsigned        idx;
			idx = it.byte_index;
			r = '0;
			case (it.req_type)
				xpf_pkg::REQ_SOURCE: begin
					open_block();
					if (mode == xpf_pkg::MODE_ENCODE) begin
						if (idx < xpf_pkg::MAX_SYMBOL_BYTES) begin
							grow_to(idx);
							par_mem[idx] ^= it.data_byte;
						end else
							too_long = 1;
					end else if (idx < par_len)
						par_mem[idx] ^= it.data_byte;
					if (it.symbol_end)
						count_symbol();
				end
				xpf_pkg::REQ_REPAIR: if (mode == xpf_pkg::MODE_DECODE) begin
					open_block();
					if (idx < xpf_pkg::MAX_SYMBOL_BYTES) begin
						grow_to(idx);
						par_mem[idx] = it.data_byte;
					end else
						too_long = 1;
				end
				xpf_pkg::REQ_LOST: if (mode == xpf_pkg::MODE_DECODE) begin
					open_block();
					lost_at = 8'(sym_cnt);
					if (lost_cnt < 2)
						lost_cnt++;
					count_symbol();
				end
				xpf_pkg::REQ_END: begin
					closed = 1;
					if (mode == xpf_pkg::MODE_ENCODE) begin
						if (sym_cnt == 0)
							st = xpf_pkg::STAT_INVALID;
						else if (too_long)
							st = xpf_pkg::STAT_TOO_LONG;
						else if (par_len == 0)
							st = xpf_pkg::STAT_INVALID;
						else
							st = xpf_pkg::STAT_OK;
					end else begin
						if (sym_cnt < 2 || too_long || par_len == 0)
							st = xpf_pkg::STAT_INVALID;
						else if (lost_cnt == 0)
							st = xpf_pkg::STAT_NONE_LOST;
						else if (lost_cnt >= 2)
							st = xpf_pkg::STAT_MANY_LOST;
						else
							st = xpf_pkg::STAT_OK;
						if (st == xpf_pkg::STAT_OK)
							r.lost_index = lost_at;
					end
					r.result_kind = xpf_pkg::KIND_STATUS;
					r.status      = st;
					if (st == xpf_pkg::STAT_OK)
						r.out_length = 12'(par_len);
					expected_replies.push_back(r);
				end
				xpf_pkg::REQ_READ: begin
					r.result_kind = xpf_pkg::KIND_READ;
					if (idx < par_len)
						r.out_byte = par_mem[idx];
					r.out_length = 12'(par_len);
					expected_replies.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task log_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task cmp_field(string name, logic [11:0] got, logic [11:0] want);
			if (got !== want)
				log_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check_reply(xpf_pkg::rsp_item_t got);
			xpf_pkg::rsp_item_t want;
			if (expected_replies.size() == 0) begin
				log_mismatch($sformatf("reply with none expected: %p", got));
				return;
			end
			want = expected_replies.pop_front();
			cmp_field("result_kind", got.result_kind, want.result_kind);
			cmp_field("status", got.status, want.status);
			cmp_field("out_byte", got.out_byte, want.out_byte);
			cmp_field("out_length", got.out_length, want.out_length);
			cmp_field("lost_index", got.lost_index, want.lost_index);
		endtask
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	xpf_pkg::req_item_t req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	xpf_pkg::rsp_item_t rsp;

	bit quiet;     // no idling on either side
	bit hold_rsp;  // asks the reply side for one long hold-off
	int fed;       // accepted items that the block acts on

	parity_scoreboard sb = new();

	xor_parity_fec_codec uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("** xor_parity_fec_codec: FAILED **");
		$finish;
	end

	initial begin : reply_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_reply(rsp);
			if (stall_left == 0 && hold_rsp) begin
				hold_rsp   = 0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 13);
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else
				rsp_stall <= 1'b0;
		end
	end

	task automatic put_req(input logic [2:0] kind, input logic [7:0] data,
			input logic [15:0] idx, input logic last);
		xpf_pkg::req_item_t it;
		it = '{req_type: kind, data_byte: data, byte_index: idx, symbol_end: last};
		if (!quiet && $urandom_range(0, 9) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall);
		sb.note_request(it);
		if (kind == xpf_pkg::REQ_SOURCE || kind == xpf_pkg::REQ_END
				|| kind == xpf_pkg::REQ_READ
				|| ((kind == xpf_pkg::REQ_REPAIR || kind == xpf_pkg::REQ_LOST)
				    && sb.mode == xpf_pkg::MODE_DECODE))
			fed++;
	endtask

	task automatic put_noise();
		put_req(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 1'($urandom));
	endtask

	task automatic put_read();
		if ($urandom_range(0, 9) == 0)
			put_req(xpf_pkg::REQ_READ, 8'($urandom), 16'($urandom), 1'($urandom));
		else
			put_req(xpf_pkg::REQ_READ, 8'($urandom), 16'($urandom_range(0, sb.par_len + 1)),
				1'b0);
	endtask

	task automatic wait_replies();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_replies.size() != 0);
	endtask

	// items that give no reply may still be in the back end
	task automatic drain();
		wait_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.mode   = m;
	endtask

	task automatic finish_block();
		if ($urandom_range(0, 7) != 0)
			put_req(xpf_pkg::REQ_END, 8'($urandom), 16'($urandom), 1'($urandom));
		repeat ($urandom_range(1, 4))
			put_read();
		if ($urandom_range(0, 7) == 0)
			put_req(xpf_pkg::REQ_END, 8'($urandom), 16'($urandom), 1'($urandom));
	endtask

	task automatic encode_block();
		int nsym, len, idx;
		nsym = $urandom_range(1, 4);
		for (int s = 0; s < nsym; s++) begin
			len = $urandom_range(1, 12);
			idx = 0;
			for (int b = 0; b < len; b++) begin
				if ($urandom_range(0, 14) == 0)
					put_noise();
				if ($urandom_range(0, 29) == 0)
					idx += $urandom_range(2, 600);
				if (idx >= xpf_pkg::MAX_SYMBOL_BYTES || $urandom_range(0, 39) == 0)
					put_req(xpf_pkg::REQ_SOURCE, 8'($urandom),
						16'($urandom_range(xpf_pkg::MAX_SYMBOL_BYTES, 65535)), b == len - 1);
				else
					put_req(xpf_pkg::REQ_SOURCE, 8'($urandom), 16'(idx), b == len - 1);
				idx++;
			end
		end
		finish_block();
	endtask

	task automatic decode_block();
		int rlen, nsym, lost_a, lost_b, len;
		rlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
		for (int b = 0; b < rlen; b++) begin
			if ($urandom_range(0, 24) == 0)
				put_req(xpf_pkg::REQ_REPAIR, 8'($urandom),
					16'($urandom_range(xpf_pkg::MAX_SYMBOL_BYTES, 65535)), 1'($urandom));
			else
				put_req(xpf_pkg::REQ_REPAIR, 8'($urandom), 16'(b), 1'($urandom));
		end
		nsym = $urandom_range(0, 5);
		// marker slot s sits before symbol s; nsym + 1 means no marker
		lost_a = $urandom_range(0, nsym + 1);
		lost_b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nsym) : nsym + 1;
		for (int s = 0; s <= nsym; s++) begin
			if (s == lost_a)
				put_req(xpf_pkg::REQ_LOST, 8'($urandom), 16'($urandom), 1'($urandom));
			if (s == lost_b)
				put_req(xpf_pkg::REQ_LOST, 8'($urandom), 16'($urandom), 1'($urandom));
			if (s < nsym) begin
				len = $urandom_range(1, rlen + 3);
				for (int b = 0; b < len; b++) begin
					if ($urandom_range(0, 19) == 0)
						put_req(xpf_pkg::REQ_REPAIR, 8'($urandom),
							16'($urandom_range(0, rlen + 3)), 1'b0);
					if ($urandom_range(0, 14) == 0)
						put_noise();
					put_req(xpf_pkg::REQ_SOURCE, 8'($urandom), 16'(b), b == len - 1);
				end
			end
		end
		finish_block();
	endtask

	// symbol count saturates, so the marker lands at the top position
	task automatic many_symbols();
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_REPAIR, 8'hC3, 16'h0000, 1'b0);
		repeat (xpf_pkg::MAX_SYMBOLS + 5)
			put_req(xpf_pkg::REQ_SOURCE, 8'($urandom), 16'($urandom_range(1, 65535)), 1'b1);
		put_req(xpf_pkg::REQ_LOST, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'h0000, 1'b0);
	endtask

	task automatic directed_encode();
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);      // no symbols yet
		put_req(xpf_pkg::REQ_SOURCE, 8'hFF, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'h00, 16'h0003, 1'b1);   // skips 1 and 2
		put_req(xpf_pkg::REQ_SOURCE, 8'h0F, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'hAA, 16'h0001, 1'b1);
		put_req(xpf_pkg::REQ_REPAIR, 8'h12, 16'h0000, 1'b0);   // dropped while encoding
		put_req(xpf_pkg::REQ_LOST, 8'h00, 16'h0000, 1'b0);
		put_req(REQ_UNKNOWN_LO, 8'hFF, 16'hFFFF, 1'b1);
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);      // again, same state
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'h0002, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'h0004, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'hFFFF, 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'h55, 16'(xpf_pkg::MAX_SYMBOL_BYTES - 1), 1'b1);
		put_req(xpf_pkg::REQ_SOURCE, 8'hFF, 16'hFFFF, 1'b1);   // too long, still a symbol
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'(xpf_pkg::MAX_SYMBOL_BYTES - 1), 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);      // no complete symbol
	endtask

	task automatic directed_decode();
		put_req(xpf_pkg::REQ_REPAIR, 8'h11, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_REPAIR, 8'h22, 16'h0001, 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'h01, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'h77, 16'h0005, 1'b1);   // past the repair length
		put_req(xpf_pkg::REQ_LOST, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_SOURCE, 8'h02, 16'h0001, 1'b1);
		put_req(xpf_pkg::REQ_END, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'h0000, 1'b0);
		put_req(xpf_pkg::REQ_READ, 8'h00, 16'h0001, 1'b0);
		put_req(REQ_UNKNOWN_HI, 8'h00, 16'h0000, 1'b0);
	endtask

	initial begin : stimulus
		int target;
		bit paused;
		paused = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(xpf_pkg::MODE_ENCODE);
		directed_encode();
		drain();
		write_mode(xpf_pkg::MODE_DECODE);
		directed_decode();
		drain();
		fed = 0;
		for (int p = 0; p < 6; p++) begin
			write_mode(p % 2 ? xpf_pkg::MODE_DECODE : xpf_pkg::MODE_ENCODE);
			quiet  = (p == 5);
			target = fed + 40;
			if (p == 1) begin
				hold_rsp = 1;
				repeat (16)
					put_read();
			end
			if (p == 3)
				many_symbols();
			while (fed < target) begin
				if (sb.mode == xpf_pkg::MODE_ENCODE)
					encode_block();
				else
					decode_block();
				if (p == 2 && !paused && fed > target - 50) begin
					wait_replies();
					paused = 1;
				end
			end
			drain();
		end
		if (sb.errors == 0 && sb.expected_replies.size() == 0)
			$display("** xor_parity_fec_codec: PASSED **");
		else
			$display("** xor_parity_fec_codec: FAILED **");
		$finish;
	end

endmodule
